/* rtl/core/u128a_pkg.sv */
// ----------------------------------------------------------------------------
// u128a_pkg: shared types for the 128-bit unsigned ALU
// Operation codes, error codes, beat structs and pipeline sizes.
// ----------------------------------------------------------------------------
package u128a_pkg;

  localparam int unsigned DivStages = 64;

  typedef enum logic [4:0] {
    KIND_MUL  = 5'd0,
    KIND_DIV  = 5'd1,
    KIND_MOD  = 5'd2,
    KIND_OR   = 5'd3,
    KIND_AND  = 5'd4,
    KIND_XOR  = 5'd5,
    KIND_SHR  = 5'd6,
    KIND_SHL  = 5'd7,
    KIND_ADD  = 5'd8,
    KIND_SUB  = 5'd9,
    KIND_LT   = 5'd10,
    KIND_GT   = 5'd11,
    KIND_LE   = 5'd12,
    KIND_GE   = 5'd13,
    KIND_EQ   = 5'd14,
    KIND_NE   = 5'd15,
    KIND_CAST = 5'd16,
    KIND_NOT  = 5'd17,
    KIND_NEG  = 5'd18,
    KIND_LNOT = 5'd19
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_MUL_WIDE = 2'd1,
    ERR_DIV_WIDE = 2'd2,
    ERR_DIV_ZERO = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    WC_32  = 2'd0,
    WC_64  = 2'd1,
    WC_128 = 2'd2
  } wclass_e;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] left_lo;
    logic [63:0] left_hi;
    logic [63:0] right_lo;
    logic [63:0] right_hi;
  } in_t;

  typedef struct packed {
    logic [63:0] result_lo;
    logic [63:0] result_hi;
    wclass_e     width_class;
    err_e        error_code;
  } out_t;

  typedef struct packed {
    logic en;
  } div_ctrl_t;

endpackage

/* rtl/core/u128a_div.sv */
// ----------------------------------------------------------------------------
// u128a_div: pipelined 64-bit restoring divider
// One quotient bit per stage; all stages advance together on the enable.
// ----------------------------------------------------------------------------
module u128a_div import u128a_pkg::*; (
  input  logic        clk_i,
  input  div_ctrl_t   ctrl_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic [63:0] quot_o,
  output logic [63:0] rem_o
);

  logic [63:0] rem_q [DivStages];
  logic [63:0] quo_q [DivStages];
  logic [63:0] dsr_q [DivStages];
  logic [63:0] rem_in [DivStages];
  logic [63:0] quo_in [DivStages];
  logic [63:0] dsr_in [DivStages];
  logic [63:0] rem_d [DivStages];
  logic [63:0] quo_d [DivStages];

  for (genvar j = 0; j < DivStages; j++) begin : g_stage
    logic [64:0] shifted;
    logic [64:0] diff;

    if (j == 0) begin : g_first
      assign rem_in[j] = '0;
      assign quo_in[j] = dividend_i;
      assign dsr_in[j] = divisor_i;
    end else begin : g_next
      assign rem_in[j] = rem_q[j-1];
      assign quo_in[j] = quo_q[j-1];
      assign dsr_in[j] = dsr_q[j-1];
    end

    always_comb begin
      shifted = {rem_in[j], quo_in[j][63]};
      diff    = shifted - {1'b0, dsr_in[j]};
      if (!diff[64]) begin
        rem_d[j] = diff[63:0];
        quo_d[j] = {quo_in[j][62:0], 1'b1};
      end else begin
        rem_d[j] = shifted[63:0];
        quo_d[j] = {quo_in[j][62:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en) begin
        rem_q[j] <= rem_d[j];
        quo_q[j] <= quo_d[j];
        dsr_q[j] <= dsr_in[j];
      end
    end
  end

  assign quot_o = quo_q[DivStages-1];
  assign rem_o  = rem_q[DivStages-1];

endmodule

/* rtl/core/uint128_alu.sv */
// ----------------------------------------------------------------------------
// uint128_alu: pipelined 128-bit unsigned integer ALU
// Logic, shift, add/subtract, compare, unary, 64x64 multiply and 64-bit divide per beat.
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_ready_o | in_i  (in_t)
//   out     | output    | out_valid_o/out_ready_i | out_o (out_t)
//
// The input register is loaded at the accepting edge; the 64 one-bit divider
// stages and the output register follow it in that order, and each result beat
// is presented from the output register. A beat is accepted every cycle while
// the output is not held. Reset clears only the stage valid bits.
// When the output beat is held, the whole pipeline holds and input ready drops.
module uint128_alu import u128a_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  logic          adv;
  logic          v1_q;
  in_t           in_q;
  logic          sv_q   [DivStages];
  kind_e         skind_q[DivStages];
  err_e          serr_q [DivStages];
  logic [127:0]  sres_q [DivStages];
  logic [63:0]   pp_q   [4];
  logic          ov_q;
  out_t          out_q;

  logic [127:0]  a, b, simple_d, mul_sum, fin_res;
  err_e          err_d;
  logic          lt, eq, big_cnt;
  logic [63:0]   quot, rem;
  div_ctrl_t     dctl;
  out_t          out_d;

  assign adv        = !ov_q || out_ready_i;
  assign in_ready_o = adv;
  assign dctl.en    = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= in_i;
    end
  end

  assign a       = {in_q.left_hi, in_q.left_lo};
  assign b       = {in_q.right_hi, in_q.right_lo};
  assign lt      = a < b;
  assign eq      = a == b;
  assign big_cnt = (in_q.right_hi != '0) || (in_q.right_lo[63:7] != '0);

  always_comb begin
    simple_d = '0;
    err_d    = ERR_NONE;
    case (in_q.kind)
      KIND_MUL: begin
        if ((in_q.left_hi | in_q.right_hi) != '0) begin
          err_d = ERR_MUL_WIDE;
        end
      end
      KIND_DIV, KIND_MOD: begin
        if ((in_q.left_hi | in_q.right_hi) != '0) begin
          err_d = ERR_DIV_WIDE;
        end else if (in_q.right_lo == '0) begin
          err_d = ERR_DIV_ZERO;
        end
      end
      KIND_OR:   simple_d = a | b;
      KIND_AND:  simple_d = a & b;
      KIND_XOR:  simple_d = a ^ b;
      KIND_SHR:  simple_d = big_cnt ? '0 : (a >> in_q.right_lo[6:0]);
      KIND_SHL:  simple_d = big_cnt ? '0 : (a << in_q.right_lo[6:0]);
      KIND_ADD:  simple_d = a + b;
      KIND_SUB:  simple_d = a - b;
      KIND_LT:   simple_d = {127'd0, lt};
      KIND_GT:   simple_d = {127'd0, !lt && !eq};
      KIND_LE:   simple_d = {127'd0, lt || eq};
      KIND_GE:   simple_d = {127'd0, !lt};
      KIND_EQ:   simple_d = {127'd0, eq};
      KIND_NE:   simple_d = {127'd0, !eq};
      KIND_CAST: simple_d = a;
      KIND_NOT:  simple_d = ~a;
      KIND_NEG:  simple_d = '0 - a;
      KIND_LNOT: simple_d = {127'd0, a == '0};
      default:   simple_d = '0;
    endcase
  end

  assign mul_sum = {64'd0, pp_q[0]} + {32'd0, pp_q[1], 32'd0}
                 + {32'd0, pp_q[2], 32'd0} + {pp_q[3], 64'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivStages; i++) begin
        sv_q[i] <= 1'b0;
      end
    end else if (adv) begin
      sv_q[0] <= v1_q;
      for (int i = 1; i < DivStages; i++) begin
        sv_q[i] <= sv_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      skind_q[0] <= in_q.kind;
      serr_q[0]  <= err_d;
      sres_q[0]  <= simple_d;
      pp_q[0]    <= in_q.left_lo[31:0]  * in_q.right_lo[31:0];
      pp_q[1]    <= in_q.left_lo[31:0]  * in_q.right_lo[63:32];
      pp_q[2]    <= in_q.left_lo[63:32] * in_q.right_lo[31:0];
      pp_q[3]    <= in_q.left_lo[63:32] * in_q.right_lo[63:32];
      skind_q[1] <= skind_q[0];
      serr_q[1]  <= serr_q[0];
      sres_q[1]  <= (skind_q[0] == KIND_MUL) ? mul_sum : sres_q[0];
      for (int i = 2; i < DivStages; i++) begin
        skind_q[i] <= skind_q[i-1];
        serr_q[i]  <= serr_q[i-1];
        sres_q[i]  <= sres_q[i-1];
      end
    end
  end

  u128a_div u_div (
    .clk_i      (clk_i),
    .ctrl_i     (dctl),
    .dividend_i (in_q.left_lo),
    .divisor_i  (in_q.right_lo),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  always_comb begin
    if (serr_q[DivStages-1] != ERR_NONE) begin
      fin_res = '0;
    end else if (skind_q[DivStages-1] == KIND_DIV) begin
      fin_res = {64'd0, quot};
    end else if (skind_q[DivStages-1] == KIND_MOD) begin
      fin_res = {64'd0, rem};
    end else begin
      fin_res = sres_q[DivStages-1];
    end
    out_d.result_lo  = fin_res[63:0];
    out_d.result_hi  = fin_res[127:64];
    out_d.error_code = serr_q[DivStages-1];
    if (fin_res[127:64] != '0) begin
      out_d.width_class = WC_128;
    end else if (fin_res[63:32] != '0) begin
      out_d.width_class = WC_64;
    end else begin
      out_d.width_class = WC_32;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= sv_q[DivStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_o       = out_q;

endmodule

/* sim/uint128_alu_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uint128_alu_checker: result predictor and scoreboard for the 128-bit ALU
// Computes the expected result of every accepted input beat and compares it,
// field by field, with each accepted output beat in order.
// ----------------------------------------------------------------------------
module uint128_alu_checker import u128a_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_i,
  output int   fail_count_o,
  output int   pending_o
);

  out_t result_fifo[$];

  function automatic out_t alu_result(in_t op);
    out_t       r;
    logic [127:0] a, b, v;
    logic       lt, eq, t;
    a = {op.left_hi, op.left_lo};
    b = {op.right_hi, op.right_lo};
    v = '0;
    r.error_code = ERR_NONE;
    case (op.kind)
      KIND_MUL: begin
        if (op.left_hi != 0 || op.right_hi != 0) r.error_code = ERR_MUL_WIDE;
        else v = {64'd0, op.left_lo} * {64'd0, op.right_lo};
      end
      KIND_DIV, KIND_MOD: begin
        if (op.left_hi != 0 || op.right_hi != 0) r.error_code = ERR_DIV_WIDE;
        else if (op.right_lo == 0) r.error_code = ERR_DIV_ZERO;
        else if (op.kind == KIND_DIV) v = {64'd0, op.left_lo / op.right_lo};
        else v = {64'd0, op.left_lo % op.right_lo};
      end
      KIND_OR:  v = a | b;
      KIND_AND: v = a & b;
      KIND_XOR: v = a ^ b;
      KIND_SHR: v = (b >= 128) ? '0 : a >> b[6:0];
      KIND_SHL: v = (b >= 128) ? '0 : a << b[6:0];
      KIND_ADD: v = a + b;
      KIND_SUB: v = a - b;
      KIND_LT, KIND_GT, KIND_LE, KIND_GE, KIND_EQ, KIND_NE: begin
        lt = a < b;
        eq = a == b;
        case (op.kind)
          KIND_LT: t = lt;
          KIND_GT: t = !lt && !eq;
          KIND_LE: t = lt || eq;
          KIND_GE: t = !lt;
          KIND_EQ: t = eq;
          default: t = !eq;
        endcase
        v = {127'd0, t};
      end
      KIND_CAST: v = a;
      KIND_NOT:  v = ~a;
      KIND_NEG:  v = -a;
      KIND_LNOT: v = {127'd0, a == 0};
      default:   v = '0;
    endcase
    r.result_lo = v[63:0];
    r.result_hi = v[127:64];
    if (v[127:64] != 0) r.width_class = WC_128;
    else if (v[63:32] != 0) r.width_class = WC_64;
    else r.width_class = WC_32;
    return r;
  endfunction

  initial fail_count_o = 0;
  assign pending_o = result_fifo.size();

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) result_fifo.push_back(alu_result(in_i));
      if (out_valid_i && out_ready_i) begin
        if (result_fifo.size() == 0) begin
          $display("%0t: unexpected output beat %h", $time, out_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = result_fifo.pop_front();
          if (want.result_lo !== out_i.result_lo || want.result_hi !== out_i.result_hi
              || want.width_class !== out_i.width_class
              || want.error_code !== out_i.error_code) begin
            $display("%0t: mismatch expected lo=%h hi=%h wc=%0d err=%0d", $time,
                     want.result_lo, want.result_hi, want.width_class, want.error_code);
            $display("%0t:          actual   lo=%h hi=%h wc=%0d err=%0d", $time,
                     out_i.result_lo, out_i.result_hi, out_i.width_class, out_i.error_code);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

/* sim/uint128_alu_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uint128_alu_test: testbench top for the 128-bit ALU
// Drives directed and random operations under varying idle and stall
// patterns, including a long output hold-off, and reports the verdict.
// ----------------------------------------------------------------------------
module uint128_alu_test;
  import u128a_pkg::*;

  localparam int unsigned Latency = DivStages + 2;
  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_beat = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_beat;
  int   fail_count;
  int   pending;
  int   send_idle = 0;
  int   recv_stall = 0;
  bit   hold_off = 1'b0;
  int   cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  uint128_alu u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_beat),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_beat)
  );

  uint128_alu_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_i        (in_beat),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_i       (out_beat),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic logic [63:0] rand64();
    logic [63:0] x;
    x = {$urandom, $urandom};
    case ($urandom_range(5))
      0: x = '0;
      1: x = '1;
      2: x = x & 64'hffff_ffff;
      3: x = x & 64'hff;
      default: ;
    endcase
    return x;
  endfunction

  task automatic send_beat(in_t op);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_beat  <= op;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_op(kind_e k, logic [63:0] al, logic [63:0] ah,
                         logic [63:0] bl, logic [63:0] bh);
    in_t op;
    op.kind = k;
    op.left_lo = al;
    op.left_hi = ah;
    op.right_lo = bl;
    op.right_hi = bh;
    send_beat(op);
  endtask

  task automatic send_random(int count);
    in_t op;
    repeat (count) begin
      op.kind = kind_e'($urandom_range(31) < 28 ? $urandom_range(19) : $urandom_range(31));
      op.left_lo = rand64();
      op.left_hi = ($urandom_range(2) == 0) ? '0 : rand64();
      op.right_lo = rand64();
      op.right_hi = ($urandom_range(2) == 0) ? '0 : rand64();
      if ((op.kind == KIND_SHR || op.kind == KIND_SHL) && $urandom_range(3) != 0) begin
        op.right_hi = '0;
        op.right_lo = 64'($urandom_range(130));
      end
      send_beat(op);
    end
  endtask

  initial begin
    int waited;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_op(KIND_MUL, '1, 0, '1, 0);
    send_op(KIND_MUL, 5, 1, 7, 0);
    send_op(KIND_DIV, '1, 0, 3, 0);
    send_op(KIND_MOD, '1, 0, 10, 0);
    send_op(KIND_DIV, 9, 0, 9, 1);
    send_op(KIND_MOD, 9, 0, 0, 0);
    send_op(KIND_DIV, 9, 0, 0, 0);
    send_op(KIND_OR, 64'h0f, '1, 64'hf0, 0);
    send_op(KIND_AND, '1, '1, 64'h1234, '1);
    send_op(KIND_XOR, '1, 0, 0, '1);
    send_op(KIND_SHR, '1, 64'h8000_0000_0000_0001, 1, 0);
    send_op(KIND_SHR, 0, 64'h8000_0000_0000_0000, 64, 0);
    send_op(KIND_SHR, '1, '1, 0, 0);
    send_op(KIND_SHL, '1, '1, 128, 0);
    send_op(KIND_SHL, 64'h8000_0000_0000_0001, 0, 127, 0);
    send_op(KIND_SHL, 1, 0, 3, 1);
    send_op(KIND_ADD, '1, '1, 1, 0);
    send_op(KIND_SUB, 0, 0, 1, 0);
    send_op(KIND_LT, 1, 5, 2, 5);
    send_op(KIND_GT, 3, 0, 3, 0);
    send_op(KIND_LE, 3, 0, 3, 0);
    send_op(KIND_GE, 0, 1, '1, 0);
    send_op(KIND_EQ, '1, '1, '1, '1);
    send_op(KIND_NE, '1, '1, '1, 0);
    send_op(KIND_CAST, 64'h1_0000_0000, 0, '1, '1);
    send_op(KIND_NOT, 0, 0, 0, 0);
    send_op(KIND_NEG, 1, 0, 0, 0);
    send_op(KIND_LNOT, 0, 0, '1, '1);
    send_op(kind_e'(5'd31), '1, '1, '1, '1);
    send_random(100);
    send_idle = 79;
    send_random(90);
    send_idle = 0;
    recv_stall = 79;
    send_random(90);
    send_idle = 33;
    recv_stall = 33;
    send_random(90);
    send_idle = 0;
    recv_stall = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_random(100);
        in_valid <= 1'b0;
      end
    join
    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (Latency + 10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
